/* design/ptwa_pkg.sv */
// Shared types and constants for the peer table with aging.
// No dependencies; used by ptwa_cell and peer_table_with_aging_unit.
package ptwa_pkg;

	localparam int DEF_ENTRIES = 32;
	localparam int MAC_W = 48;
	localparam int TIME_W = 32;
	localparam int IDX_W = 8;
	localparam int CNT_W = 9;
	localparam int OUT_CNT_W = 6;
	localparam int ADDR_W = 3;
	localparam logic [ADDR_W-1:0] ADDR_PRUNE_AGE = 3'd0;
	localparam logic [TIME_W-1:0] PRUNE_AGE_RST = 32'd30000;

	typedef enum logic [1:0] {
		FN_ADD    = 2'd0,
		FN_REMOVE = 2'd1,
		FN_FIND   = 2'd2,
		FN_PRUNE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2
	} status_t;

	typedef struct packed {
		logic              tok;
		logic              hit;
		logic [TIME_W-1:0] found_ms;
		logic              free_ok;
		logic [IDX_W-1:0]  free_idx;
		logic [CNT_W-1:0]  pruned;
	} chain_t;

	typedef struct packed {
		func_t             func;
		logic [MAC_W-1:0]  mac;
		logic [TIME_W-1:0] now_ms;
		logic [TIME_W-1:0] age_ms;
	} req_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  idx;
		logic [MAC_W-1:0]  mac;
		logic [TIME_W-1:0] now_ms;
	} wr_t;

endpackage

/* design/ptwa_cell.sv */
// One table entry: valid bit, MAC key and last-seen time.
// Evaluates the request token as it passes and hands the token to its neighbor.
// Depends on ptwa_pkg.
module ptwa_cell
	import ptwa_pkg::*;
#(
	parameter int CELL_IDX = 0
) (
	input  logic   clk,
	input  logic   arst_n,
	input  req_t   req,
	input  wr_t    wr,
	input  chain_t chain_in,
	output chain_t chain_out
);

	logic              valid_q;
	logic [MAC_W-1:0]  mac_q;
	logic [TIME_W-1:0] last_q;
	logic              match;
	logic              aged;
	logic              wr_sel;
	logic [TIME_W-1:0] elapsed;
	chain_t            out_q;

	assign match   = valid_q && (mac_q == req.mac);
	assign elapsed = req.now_ms - last_q;
	assign aged    = chain_in.tok && (req.func == FN_PRUNE) && valid_q &&
	                 (elapsed > req.age_ms);
	assign wr_sel  = wr.en && (wr.idx == IDX_W'(CELL_IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_sel) begin
			valid_q <= 1'b1;
		end else if (chain_in.tok && (req.func == FN_REMOVE) && match) begin
			valid_q <= 1'b0;
		end else if (aged) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_sel) begin
			mac_q  <= wr.mac;
			last_q <= wr.now_ms;
		end else if (chain_in.tok && (req.func == FN_ADD) && match) begin
			last_q <= req.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else begin
			out_q.tok      <= chain_in.tok;
			out_q.hit      <= chain_in.hit | match;
			out_q.found_ms <= match ? last_q : chain_in.found_ms;
			out_q.free_ok  <= chain_in.free_ok | ~valid_q;
			out_q.free_idx <= (!chain_in.free_ok && !valid_q) ? IDX_W'(CELL_IDX)
			                                                   : chain_in.free_idx;
			out_q.pruned   <= chain_in.pruned + CNT_W'(aged);
		end
	end

	assign chain_out = out_q;

endmodule

/* design/peer_table_with_aging_unit.sv */
// Top level of the peer table with aging: stream ports, APB register, controller
// and the row of entry cells. Depends on ptwa_pkg and ptwa_cell.
//
// Each request word (add, remove, find, prune) is answered by exactly one result
// word. Between acceptance and a registered result, a token walks the row of entry
// cells one cell per clock, each cell comparing its key, aging its entry or
// reporting a free slot, and the controller then commits a new entry and the peer
// count. The next request is taken once the result has been registered, even
// while that result still waits on the output. New peers go into the lowest free
// entry; prune_age_ms sits at address 0 and resets to 30000.
module peer_table_with_aging_unit
	import ptwa_pkg::*;
#(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input  logic              clk,
	input  logic              arst_n,
	// s_tdata: func[1:0], peer_mac[49:2], now_ms[81:50], zero fill
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [87:0]       s_tdata,
	// m_tdata: status[1:0], found_last_seen_ms[33:2], peer_count[39:34],
	// pruned_count[45:40], zero fill
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [47:0]       m_tdata,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int CW = $clog2(ENTRIES + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t            state_q;
	logic              start_q;
	logic [TIME_W-1:0] age_q;
	func_t             func_q;
	logic [MAC_W-1:0]  mac_q;
	logic [TIME_W-1:0] now_q;
	chain_t            res_q;
	logic [CW-1:0]     count_q;
	logic              m_tvalid_q;
	logic [47:0]       m_tdata_q;

	req_t              req;
	wr_t               wr;
	chain_t            chain [ENTRIES+1];
	logic              in_fire;
	logic              done_fire;
	logic [CW-1:0]     count_next;
	logic [CNT_W-1:0]  count_wide;
	logic [CNT_W-1:0]  pruned_wide;
	status_t           status;
	logic [TIME_W-1:0] found_ms;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_PRUNE_AGE) ? age_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= PRUNE_AGE_RST;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_PRUNE_AGE) begin
			age_q <= pwdata;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign done_fire = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_q <= func_t'(s_tdata[1:0]);
			mac_q  <= s_tdata[49:2];
			now_q  <= s_tdata[81:50];
		end
		if (chain[ENTRIES].tok) begin
			res_q <= chain[ENTRIES];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
		end else begin
			start_q <= in_fire;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (chain[ENTRIES].tok) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (done_fire) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req.func   = func_q;
	assign req.mac    = mac_q;
	assign req.now_ms = now_q;
	assign req.age_ms = age_q;

	assign chain[0].tok      = start_q;
	assign chain[0].hit      = 1'b0;
	assign chain[0].found_ms = '0;
	assign chain[0].free_ok  = 1'b0;
	assign chain[0].free_idx = '0;
	assign chain[0].pruned   = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		ptwa_cell #(
			.CELL_IDX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.req      (req),
			.wr       (wr),
			.chain_in (chain[i]),
			.chain_out(chain[i+1])
		);
	end

	assign wr.en     = done_fire && (func_q == FN_ADD) && !res_q.hit && res_q.free_ok;
	assign wr.idx    = res_q.free_idx;
	assign wr.mac    = mac_q;
	assign wr.now_ms = now_q;

	always_comb begin
		count_next = count_q;
		status     = STAT_OK;
		found_ms   = '0;
		case (func_q)
			FN_ADD: begin
				if (!res_q.hit) begin
					if (res_q.free_ok) count_next = count_q + CW'(1);
					else status = STAT_FULL;
				end
			end
			FN_REMOVE: begin
				if (res_q.hit) count_next = count_q - CW'(1);
				else status = STAT_NOT_FOUND;
			end
			FN_FIND: begin
				if (res_q.hit) found_ms = res_q.found_ms;
				else status = STAT_NOT_FOUND;
			end
			FN_PRUNE: begin
				count_next = count_q - res_q.pruned[CW-1:0];
			end
			default: status = STAT_OK;
		endcase
	end

	assign count_wide  = CNT_W'(count_next);
	assign pruned_wide = (func_q == FN_PRUNE) ? res_q.pruned : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (done_fire) begin
				count_q    <= count_next;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			m_tdata_q <= {2'b00, pruned_wide[OUT_CNT_W-1:0],
			              count_wide[OUT_CNT_W-1:0], found_ms, status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

/* tb/sv/peer_table_with_aging_checker.sv */
`timescale 1ns / 1ps
// Checker for peer_table_with_aging_unit: watches the request, result and register
// ports, keeps its own copy of the peer table and compares every result word.
// Depends on ptwa_pkg.
module peer_table_with_aging_checker
	import ptwa_pkg::*;
#(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [87:0]       s_tdata,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [47:0]       m_tdata,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic [31:0]       prdata,
	input  logic              pready,
	output int                errors,
	output int                pending
);

	typedef struct packed {
		status_t                 status;
		logic [TIME_W-1:0]       found_ms;
		logic [OUT_CNT_W-1:0]    peers;
		logic [OUT_CNT_W-1:0]    pruned;
	} answer_t;

	logic              slot_used [ENTRIES];
	logic [MAC_W-1:0]  slot_mac  [ENTRIES];
	logic [TIME_W-1:0] slot_seen [ENTRIES];
	int                peers;
	logic [TIME_W-1:0] age_limit;
	answer_t           answers_due [$];
	answer_t           due_ans;

	function automatic int find_slot(input logic [MAC_W-1:0] mac);
		for (int i = 0; i < ENTRIES; i++)
			if (slot_used[i] && slot_mac[i] == mac)
				return i;
		return -1;
	endfunction

	task automatic serve_request(input func_t op, input logic [MAC_W-1:0] mac,
			input logic [TIME_W-1:0] now, output answer_t ans);
		int hit;
		int slot;
		int removed;
		logic [TIME_W-1:0] elapsed;
		ans = '0;
		ans.status = STAT_OK;
		removed = 0;
		hit = find_slot(mac);
		case (op)
			FN_ADD: begin
				if (hit >= 0) begin
					slot_seen[hit] = now;
				end else begin
					slot = -1;
					for (int i = ENTRIES - 1; i >= 0; i--)
						if (!slot_used[i])
							slot = i;
					if (slot >= 0) begin
						slot_used[slot] = 1'b1;
						slot_mac[slot] = mac;
						slot_seen[slot] = now;
						peers++;
					end else begin
						ans.status = STAT_FULL;
					end
				end
			end
			FN_REMOVE: begin
				if (hit >= 0) begin
					slot_used[hit] = 1'b0;
					peers--;
				end else begin
					ans.status = STAT_NOT_FOUND;
				end
			end
			FN_FIND: begin
				if (hit >= 0)
					ans.found_ms = slot_seen[hit];
				else
					ans.status = STAT_NOT_FOUND;
			end
			default: begin
				for (int i = 0; i < ENTRIES; i++) begin
					elapsed = now - slot_seen[i];
					if (slot_used[i] && elapsed > age_limit) begin
						slot_used[i] = 1'b0;
						peers--;
						removed++;
					end
				end
			end
		endcase
		ans.peers = OUT_CNT_W'(peers);
		ans.pruned = OUT_CNT_W'(removed);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++)
				slot_used[i] = 1'b0;
			peers = 0;
			age_limit = PRUNE_AGE_RST;
			answers_due.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (answers_due.size() == 0) begin
					errors++;
					$display("%0t: result word with none expected, expected nothing, actual %0h",
						$time, m_tdata);
				end else begin
					due_ans = answers_due.pop_front();
					check_field("status", 32'(due_ans.status), 32'(m_tdata[1:0]));
					check_field("found_last_seen_ms", due_ans.found_ms, m_tdata[33:2]);
					check_field("peer_count", 32'(due_ans.peers), 32'(m_tdata[39:34]));
					check_field("pruned_count", 32'(due_ans.pruned), 32'(m_tdata[45:40]));
				end
			end
			if (s_tvalid && s_tready) begin
				serve_request(func_t'(s_tdata[1:0]), s_tdata[49:2], s_tdata[81:50], due_ans);
				answers_due.push_back(due_ans);
			end
			if (psel && penable && pready && paddr == ADDR_PRUNE_AGE) begin
				if (pwrite)
					age_limit = pwdata;
				else
					check_field("prdata", age_limit, prdata);
			end
		end
		pending = answers_due.size();
	end

endmodule

/* tb/sv/tb_peer_table_with_aging_unit.sv */
`timescale 1ns / 1ps
// Top of the peer_table_with_aging_unit testbench: clock, reset, request and register
// stimulus, random back-pressure and the verdict. Depends on ptwa_pkg and the checker.
module tb_peer_table_with_aging_unit;
	import ptwa_pkg::*;

	localparam int ENTRIES = DEF_ENTRIES;
	localparam int SEGMENTS = 6;
	localparam int SEGMENT_ITEMS = 210;
	localparam int POOL_SIZE = 48;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = ENTRIES + 8;
	localparam logic [ADDR_W-1:0] ADDR_UNUSED = 3'd4;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [87:0]       s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [47:0]       m_tdata;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	int                table_errors;
	int                results_due;
	int                send_idle = 10;
	int                recv_idle = 74;
	int                stall_cycles = 0;
	logic              hold_toggle = 1'b0;
	logic              hold_seen = 1'b0;
	int                hold_left = 0;
	logic [TIME_W-1:0] clock_ms = '0;
	logic [MAC_W-1:0]  peer_keys [POOL_SIZE];

	peer_table_with_aging_unit #(.ENTRIES(ENTRIES)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	peer_table_with_aging_checker #(.ENTRIES(ENTRIES)) table_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.errors(table_errors), .pending(results_due)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (hold_toggle != hold_seen) begin
			hold_seen = hold_toggle;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic send_word(input func_t op, input logic [MAC_W-1:0] mac,
			input logic [TIME_W-1:0] now);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, now, mac, op};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (results_due != 0);
	endtask

	task automatic reg_access(input logic wr, input logic [ADDR_W-1:0] addr,
			input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_request(input logic [TIME_W-1:0] step_max);
		int roll;
		func_t op;
		logic [MAC_W-1:0] mac;
		logic [TIME_W-1:0] now;
		roll = $urandom_range(99);
		op = (roll < 48) ? FN_ADD : (roll < 62) ? FN_REMOVE : (roll < 86) ? FN_FIND : FN_PRUNE;
		if ($urandom_range(99) < 85)
			mac = peer_keys[$urandom_range(POOL_SIZE - 1)];
		else
			mac = {16'($urandom), 32'($urandom)};
		roll = $urandom_range(99);
		if (roll < 3)
			clock_ms = $urandom;
		else
			clock_ms += $urandom_range(step_max);
		now = (roll == 99) ? 32'($urandom) : clock_ms;
		send_word(op, mac, now);
	endtask

	initial begin
		logic [TIME_W-1:0] ages [SEGMENTS];
		logic [TIME_W-1:0] step_max;
		peer_keys[0] = '0;
		peer_keys[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			peer_keys[i] = {16'($urandom), 32'($urandom)};
		ages[0] = 32'd30000;
		ages[1] = 32'd0;
		ages[2] = 32'hFFFF_FFFF;
		ages[3] = 32'd1000;
		ages[4] = $urandom_range(200000, 50);
		ages[5] = 32'd30000;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_word(FN_FIND, 48'h0, 32'd0);
		send_word(FN_REMOVE, 48'h0, 32'd0);
		send_word(FN_PRUNE, '1, 32'd0);
		send_word(FN_ADD, 48'h0, 32'd0);
		send_word(FN_ADD, '1, '1);
		send_word(FN_ADD, 48'h0000_1234_5678, 32'd100);
		send_word(FN_FIND, 48'h0, 32'd5);
		send_word(FN_FIND, '1, 32'd5);
		send_word(FN_ADD, 48'h0000_1234_5678, 32'd20000);
		send_word(FN_FIND, 48'h0000_1234_5678, 32'd20001);
		send_word(FN_REMOVE, 48'h0, 32'd20002);
		send_word(FN_ADD, 48'hA5A5_5A5A_0F0F, 32'd20003);
		send_word(FN_FIND, 48'h0, 32'd20004);
		send_word(FN_PRUNE, '0, 32'd29999);
		send_word(FN_PRUNE, '0, 32'd30000);
		send_word(FN_PRUNE, '0, 32'd50004);
		send_word(FN_ADD, 48'h8000_0000_0001, 32'hFFFF_FF00);
		send_word(FN_PRUNE, '0, 32'h0000_0100);
		send_word(FN_REMOVE, 48'h8000_0000_0001, 32'h0000_0101);
		wait_idle();
		reg_access(1'b1, ADDR_UNUSED, 32'd5);
		reg_access(1'b0, ADDR_PRUNE_AGE, '0);

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			send_idle = (seg < 2) ? 10 : (seg < 4) ? 74 : 0;
			recv_idle = (seg < 2) ? 74 : (seg < 4) ? 10 : 0;
			reg_access(1'b1, ADDR_PRUNE_AGE, ages[seg]);
			reg_access(1'b0, ADDR_PRUNE_AGE, '0);
			if (ages[seg] < 64)
				step_max = 32'd16;
			else if (ages[seg] > 32'h4000_0000)
				step_max = 32'h0100_0000;
			else
				step_max = ages[seg] / 6;
			if (seg == 3)
				clock_ms = 32'hFFFF_F000;
			for (int item = 0; item < SEGMENT_ITEMS; item++) begin
				if (seg == 1 && item == 60)
					hold_toggle <= ~hold_toggle;
				random_request(step_max);
			end
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (table_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* peer_table_with_aging_unit.f */
design/ptwa_pkg.sv
design/ptwa_cell.sv
design/peer_table_with_aging_unit.sv
tb/sv/peer_table_with_aging_checker.sv
tb/sv/tb_peer_table_with_aging_unit.sv
